### sv/ppi_pkg.sv
// shared types, widths and codes for the plane primitive intersection block
`default_nettype none
package ppi_pkg;

  localparam int COORD_W    = 32;
  localparam int NORM_W     = 16;
  localparam int OFFSET_W   = 32;
  localparam int EPS_W      = 31;
  localparam int LIM_W      = 30;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int PROD_W    = COORD_W + NORM_W;
  localparam int ACC_BASE  = (COORD_W > OFFSET_W) ? COORD_W : OFFSET_W;
  localparam int DIST_W    = ACC_BASE + NORM_W + 2;
  localparam int FRAC_UP   = NORM_W - 1;
  localparam int CROSS_W   = 2 * NORM_W;
  localparam int XP_W      = CROSS_W + 1;
  localparam int SQ_W      = 2 * XP_W;
  localparam int LEN_W     = SQ_W + 2;
  localparam int LIM_SHIFT = 4 * (NORM_W - 1) - LIM_W;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [NORM_W-1:0]   norm_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic        [EPS_W-1:0]    eps_t;
  typedef logic        [LIM_W-1:0]    lim_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [DIST_W-1:0]   dist_t;
  typedef logic signed [CROSS_W-1:0]  cross_t;
  typedef logic signed [XP_W-1:0]     xp_t;
  typedef logic signed [SQ_W-1:0]     sq_t;
  typedef logic        [LEN_W-1:0]    len_t;

  typedef logic [1:0] req_t;
  typedef logic [1:0] loc_t;

  localparam req_t REQ_POINT    = 2'd0;
  localparam req_t REQ_TRIANGLE = 2'd1;
  localparam req_t REQ_BOX      = 2'd2;
  localparam req_t REQ_PLANE    = 2'd3;

  localparam loc_t LOC_BACK  = 2'd0;
  localparam loc_t LOC_ON    = 2'd1;
  localparam loc_t LOC_FRONT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_LIM = 3'd5;

  localparam norm_t   RST_NORMAL_X = norm_t'((1 << (NORM_W - 1)) - 1);
  localparam norm_t   RST_NORMAL_Y = '0;
  localparam norm_t   RST_NORMAL_Z = '0;
  localparam offset_t RST_OFFSET   = '0;
  localparam eps_t    RST_EPSILON  = eps_t'(66);
  localparam lim_t    RST_LIMIT    = lim_t'(1);

  // stage enables for one distance lane
  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctl_t;

endpackage
`default_nettype wire

### sv/ppi_dist_lane.sv
// one signed distance lane: three normal products, then offset plus product sum
`default_nettype none
module ppi_dist_lane (
  input  wire                 clk,
  input  ppi_pkg::lane_ctl_t  ctl_i,
  input  ppi_pkg::norm_t      nx_i,
  input  ppi_pkg::norm_t      ny_i,
  input  ppi_pkg::norm_t      nz_i,
  input  ppi_pkg::offset_t    offset_i,
  input  ppi_pkg::coord_t     px_i,
  input  ppi_pkg::coord_t     py_i,
  input  ppi_pkg::coord_t     pz_i,
  output ppi_pkg::dist_t      dist_o
);
  import ppi_pkg::*;

  prod_t px_r, py_r, pz_r;
  prod_t px_nxt, py_nxt, pz_nxt;
  dist_t dist_r, dist_nxt;

  always_comb begin
    px_nxt = prod_t'(nx_i) * prod_t'(px_i);
    py_nxt = prod_t'(ny_i) * prod_t'(py_i);
    pz_nxt = prod_t'(nz_i) * prod_t'(pz_i);
  end

  always_comb begin
    dist_nxt = (dist_t'(offset_i) <<< FRAC_UP) + dist_t'(px_r) + dist_t'(py_r)
             + dist_t'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en_mul) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
    if (ctl_i.en_sum) begin
      dist_r <= dist_nxt;
    end
  end

  assign dist_o = dist_r;

endmodule
`default_nettype wire

### sv/plane_primitive_intersect.sv
// Plane test pipeline: point classify, triangle, box and plane-plane tests against a held plane.
// One transaction is taken every clock cycle while in_ready is high. Its result reaches the
// output register through four register stages (products, sums, compares and squares, length
// compare). Every stage holds its own valid bit and stalls only when the stage after it is full
// and stalled. Bubbles therefore close up, and while a finished result waits at the output the
// input still takes up to three more transactions.
// Configuration writes take effect at once and belong to idle periods.
`default_nettype none
module plane_primitive_intersect (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [ppi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [ppi_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  ppi_pkg::req_t                         in_req_type,
  input  ppi_pkg::coord_t                       in_ax,
  input  ppi_pkg::coord_t                       in_ay,
  input  ppi_pkg::coord_t                       in_az,
  input  ppi_pkg::coord_t                       in_bx,
  input  ppi_pkg::coord_t                       in_by,
  input  ppi_pkg::coord_t                       in_bz,
  input  ppi_pkg::coord_t                       in_cx,
  input  ppi_pkg::coord_t                       in_cy,
  input  ppi_pkg::coord_t                       in_cz,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output ppi_pkg::loc_t                         out_location,
  output logic                                  out_hit
);
  import ppi_pkg::*;

  // configuration registers
  norm_t   normal_x_r, normal_y_r, normal_z_r;
  offset_t offset_r;
  eps_t    eps_r;
  lim_t    limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_x_r <= RST_NORMAL_X;
      normal_y_r <= RST_NORMAL_Y;
      normal_z_r <= RST_NORMAL_Z;
      offset_r   <= RST_OFFSET;
      eps_r      <= RST_EPSILON;
      limit_r    <= RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NORMAL_X:     normal_x_r <= cfg_wdata[NORM_W-1:0];
        CFG_NORMAL_Y:     normal_y_r <= cfg_wdata[NORM_W-1:0];
        CFG_NORMAL_Z:     normal_z_r <= cfg_wdata[NORM_W-1:0];
        CFG_PLANE_OFFSET: offset_r   <= cfg_wdata[OFFSET_W-1:0];
        CFG_EPSILON:      eps_r      <= cfg_wdata[EPS_W-1:0];
        CFG_PARALLEL_LIM: limit_r    <= cfg_wdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage enables
  logic en1, en2, en3, en_out;
  logic v1_r, v2_r, v3_r, out_valid_r;

  assign en_out   = !out_valid_r || out_ready;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  // corner selection: box near corner on row 0, far corner on row 1
  coord_t r0x, r0y, r0z, r1x, r1y, r1z;
  logic   is_box;

  always_comb begin
    is_box = (in_req_type == REQ_BOX);
    r0x = in_ax;
    r0y = in_ay;
    r0z = in_az;
    r1x = in_bx;
    r1y = in_by;
    r1z = in_bz;
    if (is_box && normal_x_r[NORM_W-1]) begin
      r0x = in_bx;
      r1x = in_ax;
    end
    if (is_box && normal_y_r[NORM_W-1]) begin
      r0y = in_by;
      r1y = in_ay;
    end
    if (is_box && normal_z_r[NORM_W-1]) begin
      r0z = in_bz;
      r1z = in_az;
    end
  end

  lane_ctl_t lane_ctl;
  dist_t     dist0, dist1, dist2;

  assign lane_ctl.en_mul = en1;
  assign lane_ctl.en_sum = en2;

  ppi_dist_lane u_lane0 (
    .clk(clk), .ctl_i(lane_ctl), .nx_i(normal_x_r), .ny_i(normal_y_r), .nz_i(normal_z_r),
    .offset_i(offset_r), .px_i(r0x), .py_i(r0y), .pz_i(r0z), .dist_o(dist0)
  );

  ppi_dist_lane u_lane1 (
    .clk(clk), .ctl_i(lane_ctl), .nx_i(normal_x_r), .ny_i(normal_y_r), .nz_i(normal_z_r),
    .offset_i(offset_r), .px_i(r1x), .py_i(r1y), .pz_i(r1z), .dist_o(dist1)
  );

  ppi_dist_lane u_lane2 (
    .clk(clk), .ctl_i(lane_ctl), .nx_i(normal_x_r), .ny_i(normal_y_r), .nz_i(normal_z_r),
    .offset_i(offset_r), .px_i(in_cx), .py_i(in_cy), .pz_i(in_cz), .dist_o(dist2)
  );

  // stage 1: cross product terms of the two normals
  norm_t  ox, oy, oz;
  cross_t c0_r, c1_r, c2_r, c3_r, c4_r, c5_r;
  req_t   req1_r, req2_r, req3_r;

  assign ox = in_ax[NORM_W-1:0];
  assign oy = in_ay[NORM_W-1:0];
  assign oz = in_az[NORM_W-1:0];

  always_ff @(posedge clk) begin
    if (en1) begin
      req1_r <= in_req_type;
      c0_r   <= cross_t'(normal_y_r) * cross_t'(oz);
      c1_r   <= cross_t'(normal_z_r) * cross_t'(oy);
      c2_r   <= cross_t'(normal_z_r) * cross_t'(ox);
      c3_r   <= cross_t'(normal_x_r) * cross_t'(oz);
      c4_r   <= cross_t'(normal_x_r) * cross_t'(oy);
      c5_r   <= cross_t'(normal_y_r) * cross_t'(ox);
    end
  end

  // stage 2: cross product components
  xp_t x0_r, x1_r, x2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      req2_r <= req1_r;
      x0_r   <= xp_t'(c0_r) - xp_t'(c1_r);
      x1_r   <= xp_t'(c2_r) - xp_t'(c3_r);
      x2_r   <= xp_t'(c4_r) - xp_t'(c5_r);
    end
  end

  // stage 3: band compares and squares
  dist_t eps_pos, eps_neg;
  loc_t  k0, k1, k2;
  loc_t  loc3_nxt, loc3_r;
  logic  hitg3_nxt, hitg3_r;
  sq_t   sq0_r, sq1_r, sq2_r;

  function automatic loc_t band_class(input dist_t s, input dist_t ep, input dist_t en);
    loc_t k;
    if (s < en) begin
      k = LOC_BACK;
    end else if (s > ep) begin
      k = LOC_FRONT;
    end else begin
      k = LOC_ON;
    end
    return k;
  endfunction

  always_comb begin
    eps_pos   = dist_t'({1'b0, eps_r}) <<< FRAC_UP;
    eps_neg   = -eps_pos;
    k0        = band_class(dist0, eps_pos, eps_neg);
    k1        = band_class(dist1, eps_pos, eps_neg);
    k2        = band_class(dist2, eps_pos, eps_neg);
    loc3_nxt  = LOC_BACK;
    hitg3_nxt = 1'b0;
    case (req2_r)
      REQ_POINT:    loc3_nxt  = k0;
      REQ_TRIANGLE: hitg3_nxt = !((k0 == k1) && (k1 == k2));
      REQ_BOX:      hitg3_nxt = (dist0 <= dist_t'(0)) && (dist1 >= dist_t'(0));
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      req3_r  <= req2_r;
      loc3_r  <= loc3_nxt;
      hitg3_r <= hitg3_nxt;
      sq0_r   <= sq_t'(x0_r) * sq_t'(x0_r);
      sq1_r   <= sq_t'(x1_r) * sq_t'(x1_r);
      sq2_r   <= sq_t'(x2_r) * sq_t'(x2_r);
    end
  end

  // output stage: squared cross length against the scaled limit
  len_t len_sum, lim_scaled;
  loc_t out_location_r;
  logic out_hit_r, hit_nxt;

  always_comb begin
    len_sum    = len_t'($unsigned(sq0_r)) + len_t'($unsigned(sq1_r))
               + len_t'($unsigned(sq2_r));
    lim_scaled = len_t'(limit_r) << LIM_SHIFT;
    hit_nxt    = (req3_r == REQ_PLANE) ? (len_sum >= lim_scaled) : hitg3_r;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_location_r <= loc3_r;
      out_hit_r      <= hit_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_location = out_location_r;
  assign out_hit      = out_hit_r;

  // an empty output register never holds back the input
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid_r |-> in_ready)
    else $error("input blocked while output register empty");

  // a result carries either a location or a hit, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_location_r != LOC_BACK) |-> !out_hit_r)
    else $error("location and hit both set");

  // a plane transaction leaves the band compare with no result of its own
  assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (req3_r == REQ_PLANE) |-> (loc3_r == LOC_BACK) && !hitg3_r)
    else $error("plane transaction picked up a geometric result");

  // a stalled stage keeps its transaction
  assert property (@(posedge clk) disable iff (!rst_n) v2_r && !en2 |=> v2_r)
    else $error("stalled transaction dropped");

endmodule
`default_nettype wire

### test/plane_result_checker.sv
// checker for the plane intersection block: tracks the plane registers, predicts and compares results
module plane_result_checker (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [ppi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ppi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  ppi_pkg::req_t                  in_req_type,
  input  ppi_pkg::coord_t                in_ax,
  input  ppi_pkg::coord_t                in_ay,
  input  ppi_pkg::coord_t                in_az,
  input  ppi_pkg::coord_t                in_bx,
  input  ppi_pkg::coord_t                in_by,
  input  ppi_pkg::coord_t                in_bz,
  input  ppi_pkg::coord_t                in_cx,
  input  ppi_pkg::coord_t                in_cy,
  input  ppi_pkg::coord_t                in_cz,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  ppi_pkg::loc_t                  out_location,
  input  wire                            out_hit,
  output int                             fail_count,
  output int                             awaited,
  output int                             results_seen
);
  import ppi_pkg::*;

  typedef struct packed {
    loc_t location;
    logic hit;
  } plane_answer_t;

  norm_t   nx, ny, nz;
  offset_t offs;
  eps_t    eps;
  lim_t    lim;

  plane_answer_t awaited_answers[$];
  plane_answer_t want;

  initial begin
    fail_count   = 0;
    awaited      = 0;
    results_seen = 0;
  end

  // signed distance n.p + d, with 15 extra fraction bits from the normal
  function automatic longint plane_distance(coord_t px, coord_t py, coord_t pz);
    plane_distance = longint'(offs) * (longint'(1) <<< FRAC_UP)
                   + longint'(nx) * longint'(px)
                   + longint'(ny) * longint'(py)
                   + longint'(nz) * longint'(pz);
  endfunction

  function automatic loc_t classify_point(coord_t px, coord_t py, coord_t pz);
    longint s;
    longint e;
    s = plane_distance(px, py, pz);
    e = longint'(eps) * (longint'(1) <<< FRAC_UP);
    if (s < -e) return LOC_BACK;
    if (s > e) return LOC_FRONT;
    return LOC_ON;
  endfunction

  function automatic plane_answer_t predict_plane_result(
    req_t req, coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by, coord_t bz,
    coord_t cx, coord_t cy, coord_t cz);
    plane_answer_t r;
    loc_t k0, k1, k2;
    coord_t n0, n1, n2, f0, f1, f2;
    norm_t ox, oy, oz;
    longint x0, x1, x2;
    logic [LEN_W-1:0] len, lim_sh;
    r = '0;
    case (req)
      REQ_POINT: begin
        r.location = classify_point(ax, ay, az);
      end
      REQ_TRIANGLE: begin
        k0 = classify_point(ax, ay, az);
        k1 = classify_point(bx, by, bz);
        k2 = classify_point(cx, cy, cz);
        r.hit = !(k0 == k1 && k1 == k2);
      end
      REQ_BOX: begin
        // near corner per axis by the sign of the normal, no reordering of a swapped box
        n0 = (nx >= 0) ? ax : bx;
        f0 = (nx >= 0) ? bx : ax;
        n1 = (ny >= 0) ? ay : by;
        f1 = (ny >= 0) ? by : ay;
        n2 = (nz >= 0) ? az : bz;
        f2 = (nz >= 0) ? bz : az;
        r.hit = (plane_distance(n0, n1, n2) <= 0) && (plane_distance(f0, f1, f2) >= 0);
      end
      default: begin
        ox = norm_t'(ax[NORM_W-1:0]);
        oy = norm_t'(ay[NORM_W-1:0]);
        oz = norm_t'(az[NORM_W-1:0]);
        x0 = longint'(ny) * longint'(oz) - longint'(nz) * longint'(oy);
        x1 = longint'(nz) * longint'(ox) - longint'(nx) * longint'(oz);
        x2 = longint'(nx) * longint'(oy) - longint'(ny) * longint'(ox);
        len = {{(LEN_W-64){1'b0}}, x0 * x0};
        len = len + {{(LEN_W-64){1'b0}}, x1 * x1};
        len = len + {{(LEN_W-64){1'b0}}, x2 * x2};
        lim_sh = {{(LEN_W-LIM_W){1'b0}}, lim} << LIM_SHIFT;
        r.hit = (len >= lim_sh);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      nx   = RST_NORMAL_X;
      ny   = RST_NORMAL_Y;
      nz   = RST_NORMAL_Z;
      offs = RST_OFFSET;
      eps  = RST_EPSILON;
      lim  = RST_LIMIT;
      awaited_answers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NORMAL_X:     nx   = norm_t'(cfg_wdata[NORM_W-1:0]);
          CFG_NORMAL_Y:     ny   = norm_t'(cfg_wdata[NORM_W-1:0]);
          CFG_NORMAL_Z:     nz   = norm_t'(cfg_wdata[NORM_W-1:0]);
          CFG_PLANE_OFFSET: offs = offset_t'(cfg_wdata[OFFSET_W-1:0]);
          CFG_EPSILON:      eps  = cfg_wdata[EPS_W-1:0];
          CFG_PARALLEL_LIM: lim  = cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_answers.size() == 0) begin
          $error("result transaction with no test waiting");
          fail_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (out_location !== want.location) begin
            $error("location: expected %0d, actual %0d", want.location, out_location);
            fail_count++;
          end
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, out_hit);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_answers.push_back(predict_plane_result(in_req_type, in_ax, in_ay, in_az,
                                                       in_bx, in_by, in_bz,
                                                       in_cx, in_cy, in_cz));
      end
    end
    awaited = awaited_answers.size();
  end

endmodule

### test/tb_plane_primitive_intersect.sv
// testbench top for the plane intersection block: stimulus, plane settings and verdict
module tb_plane_primitive_intersect;
  import ppi_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 125;

  localparam coord_t MAXC = coord_t'(32'h7FFFFFFF);
  localparam coord_t MINC = coord_t'(32'h80000000);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  req_t                  in_req_type = REQ_POINT;
  coord_t                in_ax = '0, in_ay = '0, in_az = '0;
  coord_t                in_bx = '0, in_by = '0, in_bz = '0;
  coord_t                in_cx = '0, in_cy = '0, in_cz = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  loc_t                  out_location;
  logic                  out_hit;

  int fail_count, awaited, results_seen;
  int items_sent   = 0;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;

  norm_t cur_nx = RST_NORMAL_X, cur_ny = RST_NORMAL_Y, cur_nz = RST_NORMAL_Z;

  plane_primitive_intersect uut (.*);

  plane_result_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("plane_primitive_intersect verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // writes all six registers back to back, upper data bits random
  task automatic set_plane(input norm_t x, input norm_t y, input norm_t z, input offset_t d,
                           input eps_t e, input lim_t l);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NORMAL_X;
    cfg_wdata <= {junk, x};
    @(posedge clk);
    junk = 16'($urandom);
    cfg_index <= CFG_NORMAL_Y;
    cfg_wdata <= {junk, y};
    @(posedge clk);
    junk = 16'($urandom);
    cfg_index <= CFG_NORMAL_Z;
    cfg_wdata <= {junk, z};
    @(posedge clk);
    cfg_index <= CFG_PLANE_OFFSET;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_index <= CFG_EPSILON;
    cfg_wdata <= {1'($urandom), e};
    @(posedge clk);
    cfg_index <= CFG_PARALLEL_LIM;
    cfg_wdata <= {2'($urandom), l};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_nx = x;
    cur_ny = y;
    cur_nz = z;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_test(input req_t req, input coord_t ax, input coord_t ay, input coord_t az,
                           input coord_t bx, input coord_t by, input coord_t bz,
                           input coord_t cx, input coord_t cy, input coord_t cz);
    bit taken;
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_ax <= ax;
    in_ay <= ay;
    in_az <= az;
    in_bx <= bx;
    in_by <= by;
    in_bz <= bz;
    in_cx <= cx;
    in_cy <= cy;
    in_cz <= cz;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // about half small coordinates so that points land near the plane and its band
  function automatic coord_t rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 600)) - 300;
      4, 5:       v = int'($urandom_range(0, 2 << 20)) - (1 << 20);
      6, 7:       v = $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0:       v = MAXC;
          1:       v = MINC;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default:    v = int'($urandom_range(0, 140)) - 70;
    endcase
    return coord_t'(v);
  endfunction

  task automatic random_test();
    req_t        req;
    coord_t      v[9];
    coord_t      t;
    norm_t       ox, oy, oz;
    logic [15:0] h;
    int          i;
    req = req_t'($urandom_range(0, 3));
    for (i = 0; i < 9; i++) v[i] = rand_coord();
    if (req == REQ_BOX && $urandom_range(0, 9) < 8) begin
      for (i = 0; i < 3; i++) begin
        if (v[i] > v[i+3]) begin
          t = v[i];
          v[i] = v[i+3];
          v[i+3] = t;
        end
      end
    end
    if (req == REQ_PLANE) begin
      case ($urandom_range(0, 3))
        0: begin
          ox = norm_t'($urandom);
          oy = norm_t'($urandom);
          oz = norm_t'($urandom);
        end
        1: begin
          ox = cur_nx;
          oy = cur_ny;
          oz = cur_nz;
        end
        2: begin
          ox = -cur_nx;
          oy = -cur_ny;
          oz = -cur_nz;
        end
        default: begin
          ox = norm_t'(int'(cur_nx) + int'($urandom_range(0, 6)) - 3);
          oy = norm_t'(int'(cur_ny) + int'($urandom_range(0, 6)) - 3);
          oz = norm_t'(int'(cur_nz) + int'($urandom_range(0, 6)) - 3);
        end
      endcase
      h = 16'($urandom);
      v[0] = {h, ox};
      h = 16'($urandom);
      v[1] = {h, oy};
      h = 16'($urandom);
      v[2] = {h, oz};
    end
    send_test(req, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
  endtask

  initial begin
    norm_t   px, py, pz, pv;
    offset_t pd;
    eps_t    pe;
    lim_t    pl;
    int      phase;
    int      n;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset plane: x = 0, band of 66
    send_test(REQ_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_POINT, 100, MAXC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
    send_test(REQ_POINT, -100, MINC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC);
    send_test(REQ_POINT, MAXC, MAXC, MAXC, 0, 0, 0, 0, 0, 0);
    send_test(REQ_POINT, MINC, MINC, MINC, 0, 0, 0, 0, 0, 0);
    send_test(REQ_POINT, 66, -1, -1, -1, -1, -1, -1, -1, -1);
    send_test(REQ_TRIANGLE, 0, 5, 5, 1, 7, 7, -1, 9, 9);
    send_test(REQ_TRIANGLE, -100, 0, 0, 100, 0, 0, 0, 0, 0);
    send_test(REQ_TRIANGLE, 100, 0, 0, 200, 0, 0, MAXC, 0, 0);
    send_test(REQ_BOX, -5, -5, -5, 5, 5, 5, -1, -1, -1);
    send_test(REQ_BOX, 0, 0, 0, 10, 10, 10, 0, 0, 0);
    send_test(REQ_BOX, 1, 1, 1, 5, 5, 5, 0, 0, 0);
    send_test(REQ_BOX, 5, 5, 5, -5, -5, -5, 0, 0, 0);
    send_test(REQ_PLANE, coord_t'(32'hFFFF7FFF), coord_t'(32'hFFFF0000), 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_PLANE, 0, coord_t'(32'h00007FFF), coord_t'(32'hFFFF0000), 0, 0, 0, 0, 0, 0);
    wait_all_results();

    // band edges and the parallel limit met exactly
    set_plane(norm_t'(16'h8000), 0, 0, 0, eps_t'(66), lim_t'(1));
    send_test(REQ_POINT, -66, 0, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_POINT, -67, 0, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_POINT, 66, 0, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_POINT, 67, 0, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_PLANE, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_PLANE, coord_t'(32'h00008000), 0, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_BOX, -5, 0, 0, 0, 0, 0, 0, 0, 0);
    send_test(REQ_BOX, -5, 0, 0, -1, 0, 0, 0, 0, 0);
    wait_all_results();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle <= (phase == 6);
      case (phase % 5)
        0: begin
          px = 0;
          py = 0;
          pz = 0;
          pv = $urandom_range(0, 1) ? norm_t'(16'h7FFF) : norm_t'(16'h8000);
          case ($urandom_range(0, 2))
            0:       px = pv;
            1:       py = pv;
            default: pz = pv;
          endcase
          pd = offset_t'(int'($urandom_range(0, 600)) - 300);
          pe = eps_t'($urandom_range(0, 300));
          pl = lim_t'($urandom_range(0, 1 << 20));
        end
        1: begin
          px = norm_t'($urandom);
          py = norm_t'($urandom);
          pz = norm_t'($urandom);
          pd = offset_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
          pe = eps_t'($urandom_range(0, 2000));
          pl = lim_t'($urandom);
        end
        2: begin
          px = norm_t'(16'h7FFF);
          py = norm_t'(16'h7FFF);
          pz = norm_t'(16'h7FFF);
          pd = offset_t'(32'h7FFFFFFF);
          pe = '1;
          pl = '1;
        end
        3: begin
          px = norm_t'(16'h8000);
          py = norm_t'(16'h8000);
          pz = norm_t'(16'h8000);
          pd = offset_t'(32'h80000000);
          pe = '0;
          pl = '0;
        end
        default: begin
          px = 0;
          py = 0;
          pz = 0;
          pd = offset_t'(int'($urandom_range(0, 800)) - 400);
          pe = eps_t'($urandom_range(0, 400));
          pl = lim_t'($urandom);
        end
      endcase
      set_plane(px, py, pz, pd, pe, pl);
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_test();
      wait_all_results();
    end

    $display("%0d test transactions sent over %0d plane settings, %0d results checked",
             items_sent, RANDOM_PHASES + 2, results_seen);
    $display("point, triangle, box and plane tests, band and limit edges, extreme registers");
    if (fail_count == 0) begin
      $display("plane_primitive_intersect verification clean");
    end else begin
      $display("plane_primitive_intersect verification failed");
    end
    $finish;
  end

endmodule
